// ===== design/mfp_pkg.sv =====
// Package for the multi-function peripheral: register indexes, op codes,
// reset table, prescaler table, sequencer states. No dependencies.
`default_nettype none
package mfp_pkg;
  localparam int NumRegs   = 24;
  localparam int NumTimers = 4;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_RAISE = 3'd2,
    OP_ACK   = 3'd3,
    OP_CLOCK = 3'd4
  } op_t;

  localparam logic [4:0] R_GPIP  = 5'd0;
  localparam logic [4:0] R_IERA  = 5'd3;
  localparam logic [4:0] R_IERB  = 5'd4;
  localparam logic [4:0] R_IPRA  = 5'd5;
  localparam logic [4:0] R_IPRB  = 5'd6;
  localparam logic [4:0] R_ISRA  = 5'd7;
  localparam logic [4:0] R_ISRB  = 5'd8;
  localparam logic [4:0] R_IMRA  = 5'd9;
  localparam logic [4:0] R_IMRB  = 5'd10;
  localparam logic [4:0] R_VR    = 5'd11;
  localparam logic [4:0] R_TACR  = 5'd12;
  localparam logic [4:0] R_TBCR  = 5'd13;
  localparam logic [4:0] R_TCDCR = 5'd14;
  localparam logic [4:0] R_TADR  = 5'd15;
  localparam logic [4:0] R_TBDR  = 5'd16;
  localparam logic [4:0] R_TCDR  = 5'd17;
  localparam logic [4:0] R_TDDR  = 5'd18;
  localparam logic [4:0] R_RSR   = 5'd21;
  localparam logic [4:0] R_TSR   = 5'd22;
  localparam logic [4:0] R_UDR   = 5'd23;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TIMER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic [9:0] ticks;
  } tmr_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tmr_stat_t;

  function automatic logic [7:0] reset_reg(input logic [4:0] r);
    logic [7:0] v;
    case (r)
      5'd0: v = 8'h7b;  5'd1: v = 8'h06;  5'd2: v = 8'h00;  5'd3: v = 8'h18;
      5'd4: v = 8'h3e;  5'd5: v = 8'h00;  5'd6: v = 8'h00;  5'd7: v = 8'h00;
      5'd8: v = 8'h00;  5'd9: v = 8'h18;  5'd10: v = 8'h3e; 5'd11: v = 8'h40;
      5'd12: v = 8'h08; 5'd13: v = 8'h01; 5'd14: v = 8'h77; 5'd15: v = 8'h01;
      5'd16: v = 8'h0d; 5'd17: v = 8'hc8; 5'd18: v = 8'h14; 5'd19: v = 8'h00;
      5'd20: v = 8'h88; 5'd21: v = 8'h01; 5'd22: v = 8'h81; default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] prescale(input logic [2:0] m);
    logic [8:0] v;
    case (m)
      3'd0: v = 9'd1;   3'd1: v = 9'd10;  3'd2: v = 9'd25;  3'd3: v = 9'd40;
      3'd4: v = 9'd125; 3'd5: v = 9'd160; 3'd6: v = 9'd250; default: v = 9'd500;
    endcase
    return v;
  endfunction

  // timer -> source bit: A=IPRA bit5, B=IPRA bit0, C=IPRB bit5, D=IPRB bit4
  function automatic logic [3:0] timer_source(input logic [1:0] ch);
    logic [3:0] v;
    case (ch)
      2'd0: v = 4'd2;  2'd1: v = 4'd7;
      2'd2: v = 4'd10; default: v = 4'd11;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== design/mfp_if.sv =====
// Valid/ready channel interfaces for the peripheral's item and result beats.
// Depends on nothing.
`default_nettype none
interface mfp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [5:0] byte_offset;
  logic [7:0] write_data;
  logic [3:0] source;
  logic [9:0] ticks;
  logic [7:0] gpio_in;
  logic [7:0] rx_byte;
  logic       rx_pending;
  modport source_mp (output valid, op, byte_offset, write_data, source, ticks,
                     gpio_in, rx_byte, rx_pending, input ready);
  modport sink (input valid, op, byte_offset, write_data, source, ticks,
                gpio_in, rx_byte, rx_pending, output ready);
endinterface

interface mfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  logic [7:0] vector;
  logic       vector_valid;
  modport source_mp (output valid, read_data, irq_request, vector, vector_valid,
                     input ready);
  modport sink (input valid, read_data, irq_request, vector, vector_valid,
                output ready);
endinterface
`default_nettype wire

// ===== design/mfp_timer_step.sv =====
// Shared timer sequencer: one prescaler subtract and data decrement per cycle
// while subtracting, across four timers. Uses mfp_pkg; register file lives in the top level.
`default_nettype none
module mfp_timer_step (
  input  logic                clk,
  input  logic                rst,
  input  mfp_pkg::tmr_cmd_t   cmd,
  input  logic [7:0]          tacr,
  input  logic [7:0]          tbcr,
  input  logic [7:0]          tcdcr,
  output logic [1:0]          ch,
  output logic                dec_en,   // decrement current timer data reg
  output mfp_pkg::tmr_stat_t  stat
);
  import mfp_pkg::*;

  logic        busy, busy_next;
  logic [1:0]  ch_next;
  logic        loaded, loaded_next;  // accumulator sum formed for this channel
  logic [10:0] acc [NumTimers];
  logic [10:0] cur, cur_next;
  logic [2:0]  mode;
  logic        run;
  logic [8:0]  t;
  logic        done;

  always_comb begin
    unique case (ch)
      2'd0: mode = tacr[2:0];
      2'd1: mode = tbcr[2:0];
      2'd2: mode = tcdcr[6:4];
      default: mode = tcdcr[2:0];
    endcase
    run = (mode != 3'd0) && !(ch == 2'd0 && tacr[3]);
    t   = prescale(mode);
  end

  // one unit: start, form the accumulator sum, compare/subtract or step to next channel
  always_comb begin
    busy_next   = busy;
    ch_next     = ch;
    loaded_next = loaded;
    cur_next    = cur;
    dec_en      = 1'b0;
    done        = 1'b0;
    if (!busy) begin
      if (cmd.start) begin
        busy_next   = 1'b1;
        ch_next     = 2'd0;
        loaded_next = 1'b0;
      end
    end else if (!loaded) begin
      cur_next    = acc[ch] + {1'b0, cmd.ticks};
      loaded_next = 1'b1;
    end else if (run && cur >= {2'b00, t}) begin
      cur_next = cur - {2'b00, t};
      dec_en   = 1'b1;
    end else begin
      loaded_next = 1'b0;
      if (ch == 2'(NumTimers - 1)) begin
        busy_next = 1'b0;
        done      = 1'b1;
      end else begin
        ch_next = ch + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ch     <= 2'd0;
      loaded <= 1'b0;
      for (int i = 0; i < NumTimers; i++) acc[i] <= '0;
    end else begin
      busy   <= busy_next;
      ch     <= ch_next;
      loaded <= loaded_next;
      if (busy && loaded && !(run && cur >= {2'b00, t}) && run)
        acc[ch] <= cur;
    end
    cur <= cur_next;
  end

  assign stat.busy = busy;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_dec_only_busy: assert property (@(posedge clk) disable iff (rst)
    dec_en |-> busy && loaded) else $error("decrement outside run");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> ch == 2'd3) else $error("done before last timer");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !busy) else $error("busy after done");
`endif
endmodule
`default_nettype wire

// ===== design/mfp_interrupt_timer_controller.sv =====
// Top level of the multi-function peripheral: register file, bus access,
// interrupt acknowledge and sequencing. Uses mfp_pkg, mfp_if, mfp_timer_step.
`default_nettype none
// Bus writes, reads, source requests and acknowledges pass from accept
// through ST_DONE into the result register. A clock advance runs the shared
// timer unit in ST_TIMER: per timer it forms the accumulator sum, subtracts
// once per prescaler period elapsed and then moves on; a stopped timer only
// forms its sum and moves on. The shortest running prescale is 10, so a timer
// sees at most 103 periods for ticks 1023. The block takes one item at a
// time; the result register frees input once taken.
module mfp_interrupt_timer_controller #(
  parameter int NUM_REGS   = mfp_pkg::NumRegs,
  parameter int NUM_TIMERS = mfp_pkg::NumTimers
) (
  input  logic clk,
  input  logic rst,
  mfp_in_if.sink       in_ch,
  mfp_out_if.source_mp out_ch
);
  import mfp_pkg::*;

  logic [7:0] regs [NUM_REGS];
  logic [7:0] reload [NUM_TIMERS];
  state_t     state, state_next;
  logic [2:0] op;
  logic [5:0] off;
  logic [7:0] wd, gpio, rxb;
  logic [3:0] src;
  logic [9:0] ticks;
  logic       rxp;
  logic       out_valid;
  logic [7:0] rd_q, vec_q;
  logic       vv_q;
  tmr_cmd_t   tcmd;
  tmr_stat_t  tstat;
  logic [1:0] tch;
  logic       dec_en;
  logic [4:0] r;
  logic       acc_in;
  logic [7:0] act_a, act_b;
  logic [7:0] rd_c, vec_c;
  logic       vv_c;
  logic [3:0] win;
  logic [4:0] tdr_idx;
  logic [7:0] tdr_dec;
  logic [3:0] tsrc;

  assign acc_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !out_valid;
  assign r = off[5:1];
  assign act_a = regs[R_IPRA] & regs[R_IMRA] & ~regs[R_ISRA];
  assign act_b = regs[R_IPRB] & regs[R_IMRB] & ~regs[R_ISRB];
  assign tdr_idx = R_TADR + {3'd0, tch};
  assign tdr_dec = regs[tdr_idx] - 8'd1;
  assign tsrc = timer_source(tch);

  assign tcmd.start = (state == ST_TIMER) && !tstat.busy && !tstat.done;
  assign tcmd.ticks = ticks;

  mfp_timer_step u_tmr (
    .clk, .rst, .cmd(tcmd), .tacr(regs[R_TACR]), .tbcr(regs[R_TBCR]),
    .tcdcr(regs[R_TCDCR]), .ch(tch), .dec_en,
    .stat(tstat)
  );

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (acc_in) state_next = (in_ch.op == OP_CLOCK) ? ST_TIMER : ST_DONE;
      ST_TIMER: if (tstat.done) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // read data and acknowledge priority
  always_comb begin
    rd_c = 8'h00;
    vec_c = 8'h00;
    vv_c = 1'b0;
    win = 4'd0;
    if (op == OP_READ) begin
      if (off > 6'd47) rd_c = 8'h00;
      else if (!off[0]) rd_c = 8'hff;
      else if (r == R_GPIP) rd_c = gpio;
      else if (r == R_UDR) rd_c = rxb;
      else if (r == R_RSR) rd_c = rxp ? (regs[r] & 8'h7f) : (regs[r] | 8'h80);
      else rd_c = regs[r];
    end
    for (int b = 0; b < 8; b++) begin
      if (act_b[b]) win = 4'(b);
    end
    for (int b = 0; b < 8; b++) begin
      if (act_a[b]) win = 4'(8 + b);
    end
    if (op == OP_ACK && (act_a != 8'h00 || act_b != 8'h00)) begin
      vv_c = 1'b1;
      vec_c = (regs[R_VR] & 8'hf0) | {4'h0, win};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= reset_reg(5'(i));
      for (int i = 0; i < NUM_TIMERS; i++) reload[i] <= 8'h00;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (dec_en) begin
        if (tdr_dec == 8'h00) begin
          regs[tdr_idx] <= reload[tch];
          if (!tsrc[3]) begin
            if (regs[R_IERA][3'd7 - tsrc[2:0]])
              regs[R_IPRA][3'd7 - tsrc[2:0]] <= 1'b1;
          end else if (regs[R_IERB][3'd7 - tsrc[2:0]]) begin
            regs[R_IPRB][3'd7 - tsrc[2:0]] <= 1'b1;
          end
        end else begin
          regs[tdr_idx] <= tdr_dec;
        end
      end
      if (state == ST_DONE) begin
        out_valid <= 1'b1;
        rd_q <= rd_c;
        vec_q <= vec_c;
        vv_q <= vv_c;
        unique case (op)
          OP_WRITE: if (off <= 6'd47 && off[0]) begin
            case (r) inside
              R_IERA, R_IERB: begin
                regs[r] <= wd;
                regs[r + 5'd2] <= regs[r + 5'd2] & wd;
              end
              R_IPRA, R_IPRB, R_ISRA, R_ISRB: regs[r] <= regs[r] & wd;
              R_TADR, R_TBDR, R_TCDR, R_TDDR: begin
                regs[r] <= wd;
                reload[2'(r - R_TADR)] <= wd;
              end
              R_TSR: regs[r] <= wd | 8'h80;
              R_UDR: ;
              default: regs[r] <= wd;
            endcase
          end
          OP_RAISE: begin
            if (!src[3]) begin
              if (regs[R_IERA][3'd7 - src[2:0]]) regs[R_IPRA][3'd7 - src[2:0]] <= 1'b1;
            end else if (regs[R_IERB][3'd7 - src[2:0]]) begin
              regs[R_IPRB][3'd7 - src[2:0]] <= 1'b1;
            end
          end
          OP_ACK: if (vv_c) begin
            if (win[3]) begin
              regs[R_IPRA][win[2:0]] <= 1'b0;
              if (regs[R_VR][3]) regs[R_ISRA][win[2:0]] <= 1'b1;
            end else begin
              regs[R_IPRB][win[2:0]] <= 1'b0;
              if (regs[R_VR][3]) regs[R_ISRB][win[2:0]] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (acc_in) begin
      op <= in_ch.op;
      off <= in_ch.byte_offset;
      wd <= in_ch.write_data;
      src <= in_ch.source;
      ticks <= in_ch.ticks;
      gpio <= in_ch.gpio_in;
      rxb <= in_ch.rx_byte;
      rxp <= in_ch.rx_pending;
    end
  end

  // irq reflects the register file after the item's update
  assign out_ch.valid        = out_valid;
  assign out_ch.read_data    = rd_q;
  assign out_ch.vector       = vec_q;
  assign out_ch.vector_valid = vv_q;
  assign out_ch.irq_request  = (act_a != 8'h00) || (act_b != 8'h00);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> !out_valid) else $error("result overwritten");
  a_vec_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && vv_q |-> vec_q[7:4] == $past(regs[R_VR][7:4]) || $past(out_valid))
    else $error("vector without vr");
`endif
endmodule
`default_nettype wire
